FILE: design/obbwb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// obbwb_pkg
// Shared widths, types, constants and rounding helpers for the world box
// pipeline.
// ----------------------------------------------------------------------------
package obbwb_pkg;

    localparam int COORD_WIDTH    = 32;
    localparam int QUAT_WIDTH     = 16;
    localparam int QPROD_WIDTH    = 2 * QUAT_WIDTH;
    localparam int MAT_FRAC       = 28;
    localparam int MAT_WIDTH      = QPROD_WIDTH + 2;
    localparam int EXT_FRAC       = 16;
    localparam int EXT_PROD_WIDTH = 2 * COORD_WIDTH;
    localparam int EXT_Q_WIDTH    = EXT_PROD_WIDTH - EXT_FRAC + 1;
    localparam int PROD_WIDTH     = MAT_WIDTH + COORD_WIDTH;
    localparam int ACC_WIDTH      = PROD_WIDTH + 2;
    localparam int ACC_Q_WIDTH    = ACC_WIDTH - MAT_FRAC + 1;
    localparam int PIPE_DEPTH     = 5;
    localparam int CFG_IDX_WIDTH  = 3;

    typedef logic signed [COORD_WIDTH-1:0]    t_coord;
    typedef logic signed [QUAT_WIDTH-1:0]     t_quat;
    typedef logic signed [QPROD_WIDTH-1:0]    t_qprod;
    typedef logic signed [MAT_WIDTH-1:0]      t_mat;
    typedef logic signed [EXT_PROD_WIDTH-1:0] t_ext_prod;
    typedef logic signed [PROD_WIDTH-1:0]     t_prod;
    typedef logic signed [ACC_WIDTH-1:0]      t_acc;
    typedef logic [CFG_IDX_WIDTH-1:0]         t_cfg_idx;

    typedef t_coord t_coord_vec [3];
    typedef t_mat   t_mat_row [3];

    localparam t_cfg_idx CFG_EXT_MIN_X = 3'd0;
    localparam t_cfg_idx CFG_EXT_MIN_Y = 3'd1;
    localparam t_cfg_idx CFG_EXT_MIN_Z = 3'd2;
    localparam t_cfg_idx CFG_EXT_MAX_X = 3'd3;
    localparam t_cfg_idx CFG_EXT_MAX_Y = 3'd4;
    localparam t_cfg_idx CFG_EXT_MAX_Z = 3'd5;

    localparam t_coord COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam t_coord COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    localparam t_mat   MAT_ONE   = MAT_WIDTH'(1) << MAT_FRAC;

    localparam logic signed [EXT_PROD_WIDTH:0] EXT_HALF = (EXT_PROD_WIDTH+1)'(1) << (EXT_FRAC-1);
    localparam logic signed [ACC_WIDTH:0]      ACC_HALF = (ACC_WIDTH+1)'(1) << (MAT_FRAC-1);

    // Round half up by EXT_FRAC bits, then clamp to the coordinate range.
    function automatic t_coord sat_round_ext(input t_ext_prod v);
        logic signed [EXT_PROD_WIDTH:0]  s;
        logic signed [EXT_Q_WIDTH-1:0]   q;
        t_coord                          r;
        s = $signed({v[EXT_PROD_WIDTH-1], v}) + EXT_HALF;
        q = $signed(s[EXT_PROD_WIDTH:EXT_FRAC]);
        if (q > EXT_Q_WIDTH'(COORD_MAX)) begin
            r = COORD_MAX;
        end else if (q < EXT_Q_WIDTH'(COORD_MIN)) begin
            r = COORD_MIN;
        end else begin
            r = q[COORD_WIDTH-1:0];
        end
        return r;
    endfunction

    // Round half up by MAT_FRAC bits, then clamp to the coordinate range.
    function automatic t_coord sat_round_acc(input t_acc v);
        logic signed [ACC_WIDTH:0]     s;
        logic signed [ACC_Q_WIDTH-1:0] q;
        t_coord                        r;
        s = $signed({v[ACC_WIDTH-1], v}) + ACC_HALF;
        q = $signed(s[ACC_WIDTH:MAT_FRAC]);
        if (q > ACC_Q_WIDTH'(COORD_MAX)) begin
            r = COORD_MAX;
        end else if (q < ACC_Q_WIDTH'(COORD_MIN)) begin
            r = COORD_MIN;
        end else begin
            r = q[COORD_WIDTH-1:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: design/obbwb_quat_mat.sv
`default_nettype none
// ----------------------------------------------------------------------------
// obbwb_quat_mat
// Two-stage quaternion to rotation matrix: pair products, then Q28 entries.
// ----------------------------------------------------------------------------
module obbwb_quat_mat (
    input  wire                   i_clk,
    input  wire                   i_en,
    input  obbwb_pkg::t_quat      i_rot_w,
    input  obbwb_pkg::t_quat      i_rot_x,
    input  obbwb_pkg::t_quat      i_rot_y,
    input  obbwb_pkg::t_quat      i_rot_z,
    output obbwb_pkg::t_mat_row   o_m [3]
);
    import obbwb_pkg::*;

    t_qprod r_xx, r_yy, r_zz, r_xy, r_xz, r_yz, r_wx, r_wy, r_wz;
    t_qprod n_xx, n_yy, n_zz, n_xy, n_xz, n_yz, n_wx, n_wy, n_wz;
    t_mat   r_m [3][3];
    t_mat   n_m [3][3];

    always_comb begin
        n_xx = t_qprod'(i_rot_x) * t_qprod'(i_rot_x);
        n_yy = t_qprod'(i_rot_y) * t_qprod'(i_rot_y);
        n_zz = t_qprod'(i_rot_z) * t_qprod'(i_rot_z);
        n_xy = t_qprod'(i_rot_x) * t_qprod'(i_rot_y);
        n_xz = t_qprod'(i_rot_x) * t_qprod'(i_rot_z);
        n_yz = t_qprod'(i_rot_y) * t_qprod'(i_rot_z);
        n_wx = t_qprod'(i_rot_w) * t_qprod'(i_rot_x);
        n_wy = t_qprod'(i_rot_w) * t_qprod'(i_rot_y);
        n_wz = t_qprod'(i_rot_w) * t_qprod'(i_rot_z);
    end

    // Products are already Q28; the doubled sums need two extra bits.
    always_comb begin
        n_m[0][0] = MAT_ONE - ((t_mat'(r_yy) + t_mat'(r_zz)) <<< 1);
        n_m[0][1] = (t_mat'(r_xy) - t_mat'(r_wz)) <<< 1;
        n_m[0][2] = (t_mat'(r_xz) + t_mat'(r_wy)) <<< 1;
        n_m[1][0] = (t_mat'(r_xy) + t_mat'(r_wz)) <<< 1;
        n_m[1][1] = MAT_ONE - ((t_mat'(r_xx) + t_mat'(r_zz)) <<< 1);
        n_m[1][2] = (t_mat'(r_yz) - t_mat'(r_wx)) <<< 1;
        n_m[2][0] = (t_mat'(r_xz) - t_mat'(r_wy)) <<< 1;
        n_m[2][1] = (t_mat'(r_yz) + t_mat'(r_wx)) <<< 1;
        n_m[2][2] = MAT_ONE - ((t_mat'(r_xx) + t_mat'(r_yy)) <<< 1);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_xx <= n_xx;
            r_yy <= n_yy;
            r_zz <= n_zz;
            r_xy <= n_xy;
            r_xz <= n_xz;
            r_yz <= n_yz;
            r_wx <= n_wx;
            r_wy <= n_wy;
            r_wz <= n_wz;
            r_m  <= n_m;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                o_m[i][j] = r_m[i][j];
            end
        end
    end

endmodule
`default_nettype wire

FILE: design/obbwb_ext_scale.sv
`default_nettype none
// ----------------------------------------------------------------------------
// obbwb_ext_scale
// Two-stage extent scaling: full products, then round and clamp to Q16.16.
// ----------------------------------------------------------------------------
module obbwb_ext_scale (
    input  wire                    i_clk,
    input  wire                    i_en,
    input  obbwb_pkg::t_coord_vec  i_ext_min,
    input  obbwb_pkg::t_coord_vec  i_ext_max,
    input  obbwb_pkg::t_coord_vec  i_scale,
    output obbwb_pkg::t_coord_vec  o_smin,
    output obbwb_pkg::t_coord_vec  o_smax
);
    import obbwb_pkg::*;

    t_ext_prod r_pmin [3];
    t_ext_prod r_pmax [3];
    t_ext_prod n_pmin [3];
    t_ext_prod n_pmax [3];
    t_coord    r_smin [3];
    t_coord    r_smax [3];
    t_coord    n_smin [3];
    t_coord    n_smax [3];

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            n_pmin[j] = t_ext_prod'(i_ext_min[j]) * t_ext_prod'(i_scale[j]);
            n_pmax[j] = t_ext_prod'(i_ext_max[j]) * t_ext_prod'(i_scale[j]);
            n_smin[j] = sat_round_ext(r_pmin[j]);
            n_smax[j] = sat_round_ext(r_pmax[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pmin <= n_pmin;
            r_pmax <= n_pmax;
            r_smin <= n_smin;
            r_smax <= n_smax;
        end
    end

    assign o_smin = r_smin;
    assign o_smax = r_smax;

endmodule
`default_nettype wire

FILE: design/obbwb_corner_axis.sv
`default_nettype none
// ----------------------------------------------------------------------------
// obbwb_corner_axis
// One world axis: matrix-row products against both extents, per-term
// min/max sums with the position, then round and clamp.
// ----------------------------------------------------------------------------
module obbwb_corner_axis (
    input  wire                    i_clk,
    input  wire                    i_en,
    input  obbwb_pkg::t_mat_row    i_m_row,
    input  obbwb_pkg::t_coord_vec  i_smin,
    input  obbwb_pkg::t_coord_vec  i_smax,
    input  obbwb_pkg::t_coord      i_pos,
    output obbwb_pkg::t_coord      o_lo,
    output obbwb_pkg::t_coord      o_hi
);
    import obbwb_pkg::*;

    t_prod  r_pa [3];
    t_prod  r_pb [3];
    t_prod  n_pa [3];
    t_prod  n_pb [3];
    t_coord r_pos;
    t_acc   r_acc_lo, r_acc_hi;
    t_acc   n_acc_lo, n_acc_hi;
    t_coord r_lo, r_hi;
    t_coord n_lo, n_hi;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            n_pa[j] = t_prod'(i_m_row[j]) * t_prod'(i_smin[j]);
            n_pb[j] = t_prod'(i_m_row[j]) * t_prod'(i_smax[j]);
        end
    end

    // The eight corners pick each term independently, so the extreme sum is
    // the sum of the per-term extremes.
    always_comb begin
        n_acc_lo = t_acc'(r_pos) <<< MAT_FRAC;
        n_acc_hi = t_acc'(r_pos) <<< MAT_FRAC;
        for (int j = 0; j < 3; j++) begin
            if (r_pa[j] < r_pb[j]) begin
                n_acc_lo = n_acc_lo + t_acc'(r_pa[j]);
                n_acc_hi = n_acc_hi + t_acc'(r_pb[j]);
            end else begin
                n_acc_lo = n_acc_lo + t_acc'(r_pb[j]);
                n_acc_hi = n_acc_hi + t_acc'(r_pa[j]);
            end
        end
        n_lo = sat_round_acc(r_acc_lo);
        n_hi = sat_round_acc(r_acc_hi);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pa     <= n_pa;
            r_pb     <= n_pb;
            r_pos    <= i_pos;
            r_acc_lo <= n_acc_lo;
            r_acc_hi <= n_acc_hi;
            r_lo     <= n_lo;
            r_hi     <= n_hi;
        end
    end

    assign o_lo = r_lo;
    assign o_hi = r_hi;

endmodule
`default_nettype wire

FILE: design/obb_world_bounding_box.sv
`default_nettype none
// ----------------------------------------------------------------------------
// obb_world_bounding_box
// World-aligned bounding box of a scaled, rotated and translated local box.
//
// Load the six local extents through the write port (i_cfg_we, i_cfg_idx,
// i_cfg_data) while the block holds no word; indexes above five are dropped.
// Each input word carries a position, a Q2.14 quaternion and a per-axis
// scale; each output word carries the per-axis minimum and maximum of the
// eight world corners in Q16.16, clamped to the coordinate range.
// The datapath is a five-stage pipeline: quaternion and extent products,
// matrix entries and rounded extents, matrix-times-extent products, min/max
// sums with the position, round and clamp. A word accepted by the block
// passes these stages in order and stays on the outputs until taken; one
// word per cycle is sustained while the receiver keeps taking words.
// The whole pipeline advances together: when the output word is held by the
// receiver, every stage holds and o_in_ready drops, so nothing is lost or
// repeated; bubbles travel as cleared valid bits.
// Reset clears the valid bits and zeroes all six extents.
// ----------------------------------------------------------------------------
module obb_world_bounding_box (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_cfg_we,
    input  obbwb_pkg::t_cfg_idx      i_cfg_idx,
    input  obbwb_pkg::t_coord        i_cfg_data,
    input  wire                      i_in_valid,
    output logic                     o_in_ready,
    input  obbwb_pkg::t_coord        i_pos_x,
    input  obbwb_pkg::t_coord        i_pos_y,
    input  obbwb_pkg::t_coord        i_pos_z,
    input  obbwb_pkg::t_quat         i_rot_w,
    input  obbwb_pkg::t_quat         i_rot_x,
    input  obbwb_pkg::t_quat         i_rot_y,
    input  obbwb_pkg::t_quat         i_rot_z,
    input  obbwb_pkg::t_coord        i_scale_x,
    input  obbwb_pkg::t_coord        i_scale_y,
    input  obbwb_pkg::t_coord        i_scale_z,
    output logic                     o_out_valid,
    input  wire                      i_out_ready,
    output obbwb_pkg::t_coord        o_box_min_x,
    output obbwb_pkg::t_coord        o_box_min_y,
    output obbwb_pkg::t_coord        o_box_min_z,
    output obbwb_pkg::t_coord        o_box_max_x,
    output obbwb_pkg::t_coord        o_box_max_y,
    output obbwb_pkg::t_coord        o_box_max_z
);
    import obbwb_pkg::*;

    logic                  w_en;
    logic [PIPE_DEPTH-1:0] r_vld;
    t_coord                r_ext_min [3];
    t_coord                r_ext_max [3];
    t_coord                r_pos1 [3];
    t_coord                r_pos2 [3];
    t_coord                w_pos [3];
    t_coord                w_scale [3];
    t_mat_row              w_m [3];
    t_coord                w_smin [3];
    t_coord                w_smax [3];
    t_coord                w_lo [3];
    t_coord                w_hi [3];

    // Advance everything unless the last stage holds an untaken word.
    assign w_en        = !r_vld[PIPE_DEPTH-1] || i_out_ready;
    assign o_in_ready  = w_en;
    assign o_out_valid = r_vld[PIPE_DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], i_in_valid};
        end
    end

    // Extent registers: write only while the pipeline is empty; unchecked.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < 3; j++) begin
                r_ext_min[j] <= '0;
                r_ext_max[j] <= '0;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_EXT_MIN_X: r_ext_min[0] <= i_cfg_data;
                CFG_EXT_MIN_Y: r_ext_min[1] <= i_cfg_data;
                CFG_EXT_MIN_Z: r_ext_min[2] <= i_cfg_data;
                CFG_EXT_MAX_X: r_ext_max[0] <= i_cfg_data;
                CFG_EXT_MAX_Y: r_ext_max[1] <= i_cfg_data;
                CFG_EXT_MAX_Z: r_ext_max[2] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign w_pos[0]   = i_pos_x;
    assign w_pos[1]   = i_pos_y;
    assign w_pos[2]   = i_pos_z;
    assign w_scale[0] = i_scale_x;
    assign w_scale[1] = i_scale_y;
    assign w_scale[2] = i_scale_z;

    // Carry the position alongside the first two stages.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pos1 <= w_pos;
            r_pos2 <= r_pos1;
        end
    end

    obbwb_quat_mat u_quat_mat (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_rot_w (i_rot_w),
        .i_rot_x (i_rot_x),
        .i_rot_y (i_rot_y),
        .i_rot_z (i_rot_z),
        .o_m     (w_m)
    );

    obbwb_ext_scale u_ext_scale (
        .i_clk     (i_clk),
        .i_en      (w_en),
        .i_ext_min (r_ext_min),
        .i_ext_max (r_ext_max),
        .i_scale   (w_scale),
        .o_smin    (w_smin),
        .o_smax    (w_smax)
    );

    // One lane per world axis, each using its own matrix row.
    for (genvar g = 0; g < 3; g++) begin : g_axis
        obbwb_corner_axis u_axis (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_m_row (w_m[g]),
            .i_smin  (w_smin),
            .i_smax  (w_smax),
            .i_pos   (r_pos2[g]),
            .o_lo    (w_lo[g]),
            .o_hi    (w_hi[g])
        );
    end

    assign o_box_min_x = w_lo[0];
    assign o_box_min_y = w_lo[1];
    assign o_box_min_z = w_lo[2];
    assign o_box_max_x = w_hi[0];
    assign o_box_max_y = w_hi[1];
    assign o_box_max_z = w_hi[2];

endmodule
`default_nettype wire

FILE: test/obb_world_bounding_box_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// obb_world_bounding_box_test
// Self-checking bench for the world box pipeline. A queue of poses feeds a
// valid/ready driver, a scoreboard predicts every output word from its own
// fixed-point model of the corner transform, and a monitor compares each
// output word field by field. Extents are reloaded between phases while the
// pipeline is empty; the handshakes idle and stall at several rates.
// ----------------------------------------------------------------------------
module obb_world_bounding_box_test;

    import obbwb_pkg::*;

    localparam int CLK_HALF       = 6;
    localparam int RESET_CYCLES   = 7;
    localparam int TIMEOUT_CYCLES = 100_000;
    localparam int LONG_HOLD      = 200;
    localparam int ITEMS_PER_PASS = 460;
    localparam int SETTLE_CYCLES  = 4 * PIPE_DEPTH;
    localparam int REPORT_LIMIT   = 10;

    // Handy Q16.16 and Q2.14 values.
    localparam t_coord FIX_ONE  = 32'sh0001_0000;
    localparam t_coord FIX_HALF = 32'sh0000_8000;
    localparam t_quat  Q_ONE    = 16'sh4000;
    localparam t_quat  Q_RT_HALF = 16'sd11585;   // cos(45 deg) in Q2.14
    localparam t_quat  Q_POS_MAX = 16'sh7fff;
    localparam t_quat  Q_NEG_MAX = 16'sh8000;

    // Indexes the block has no register for; writes there must be dropped.
    localparam t_cfg_idx CFG_IDX_UNMAPPED_6 = 3'd6;
    localparam t_cfg_idx CFG_IDX_UNMAPPED_7 = 3'd7;

    // Field positions inside one output word.
    localparam int BOX_MIN_X = 0;
    localparam int BOX_MIN_Y = 1;
    localparam int BOX_MIN_Z = 2;
    localparam int BOX_MAX_X = 3;
    localparam int BOX_MAX_Y = 4;
    localparam int BOX_MAX_Z = 5;

    typedef struct packed {
        t_coord pos_x;
        t_coord pos_y;
        t_coord pos_z;
        t_quat  rot_w;
        t_quat  rot_x;
        t_quat  rot_y;
        t_quat  rot_z;
        t_coord scale_x;
        t_coord scale_y;
        t_coord scale_z;
    } t_pose;

    typedef logic [5:0][COORD_WIDTH-1:0] t_box;
    typedef logic signed [127:0]         t_wide;

    string box_field [6] = '{"box_min_x", "box_min_y", "box_min_z",
                             "box_max_x", "box_max_y", "box_max_z"};

    // ------------------------------------------------------------------
    // DUT connections; every input starts at a known value
    // ------------------------------------------------------------------
    logic     i_clk       = 1'b0;
    logic     i_rst_n     = 1'b0;
    logic     i_cfg_we    = 1'b0;
    t_cfg_idx i_cfg_idx   = CFG_EXT_MIN_X;
    t_coord   i_cfg_data  = '0;
    logic     i_in_valid  = 1'b0;
    logic     o_in_ready;
    t_coord   i_pos_x     = '0;
    t_coord   i_pos_y     = '0;
    t_coord   i_pos_z     = '0;
    t_quat    i_rot_w     = '0;
    t_quat    i_rot_x     = '0;
    t_quat    i_rot_y     = '0;
    t_quat    i_rot_z     = '0;
    t_coord   i_scale_x   = '0;
    t_coord   i_scale_y   = '0;
    t_coord   i_scale_z   = '0;
    logic     o_out_valid;
    logic     i_out_ready = 1'b0;
    t_coord   o_box_min_x;
    t_coord   o_box_min_y;
    t_coord   o_box_min_z;
    t_coord   o_box_max_x;
    t_coord   o_box_max_y;
    t_coord   o_box_max_z;

    obb_world_bounding_box dut (.*);

    // ------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------
    t_pose  pose_backlog [$];      // poses waiting to be offered
    t_box   expected_boxes [$];    // predicted output words, oldest first
    t_coord ext_lo [3] = '{0, 0, 0};   // mirror of the extent registers
    t_coord ext_hi [3] = '{0, 0, 0};

    int offered_cnt    = 0;   // words put on the input bus (driver only)
    int accepted_cnt   = 0;   // words taken by the block (monitor only)
    int checked_cnt    = 0;
    int error_cnt      = 0;
    int setting_cnt    = 0;
    int send_idle_pct  = 0;
    int ready_stall_pct = 0;
    int stall_req_cnt  = 0;   // bumped to ask the receiver for a long hold-off
    int stall_ack_cnt  = 0;
    int hold_left      = 0;

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Round half up by sh fraction bits, then clamp to the coordinate range.
    function automatic t_coord round_clamp(input t_wide v, input int sh);
        t_wide q;
        t_wide top;
        t_wide bot;
        top = t_wide'(COORD_MAX);
        bot = t_wide'(COORD_MIN);
        q = (v + (128'sd1 <<< (sh - 1))) >>> sh;
        if (q > top) return COORD_MAX;
        if (q < bot) return COORD_MIN;
        return q[COORD_WIDTH-1:0];
    endfunction

    // World-aligned box of one pose against the current extents.
    function automatic t_box world_box(input t_pose p);
        t_wide  m [3][3];
        t_wide  cw [3];
        t_wide  acc;
        t_wide  a;
        t_wide  b;
        longint qw, qx, qy, qz, one;
        t_coord pos [3];
        t_coord scl [3];
        t_coord smin [3];
        t_coord smax [3];
        t_coord lo [3];
        t_coord hi [3];
        t_coord r;
        t_box   bx;
        qw = longint'(p.rot_w);
        qx = longint'(p.rot_x);
        qy = longint'(p.rot_y);
        qz = longint'(p.rot_z);
        one = longint'(1) <<< MAT_FRAC;
        pos[0] = p.pos_x;
        pos[1] = p.pos_y;
        pos[2] = p.pos_z;
        scl[0] = p.scale_x;
        scl[1] = p.scale_y;
        scl[2] = p.scale_z;

        // Scale the extents: exact Q32 product, back to Q16.16.
        for (int i = 0; i < 3; i++) begin
            b = t_wide'(scl[i]);
            a = t_wide'(ext_lo[i]);
            smin[i] = round_clamp(a * b, EXT_FRAC);
            a = t_wide'(ext_hi[i]);
            smax[i] = round_clamp(a * b, EXT_FRAC);
        end

        // Rotation matrix in Q28, quaternion taken as is (no normalizing).
        m[0][0] = t_wide'(one - 2 * (qy * qy + qz * qz));
        m[0][1] = t_wide'(2 * (qx * qy - qw * qz));
        m[0][2] = t_wide'(2 * (qx * qz + qw * qy));
        m[1][0] = t_wide'(2 * (qx * qy + qw * qz));
        m[1][1] = t_wide'(one - 2 * (qx * qx + qz * qz));
        m[1][2] = t_wide'(2 * (qy * qz - qw * qx));
        m[2][0] = t_wide'(2 * (qx * qz - qw * qy));
        m[2][1] = t_wide'(2 * (qy * qz + qw * qx));
        m[2][2] = t_wide'(one - 2 * (qx * qx + qy * qy));

        // Walk the eight corners; min/max over the clamped world values.
        for (int k = 0; k < 8; k++) begin
            for (int j = 0; j < 3; j++) begin
                cw[j] = k[j] ? t_wide'(smax[j]) : t_wide'(smin[j]);
            end
            for (int i = 0; i < 3; i++) begin
                a = t_wide'(pos[i]);
                acc = a <<< MAT_FRAC;
                for (int j = 0; j < 3; j++) begin
                    acc = acc + m[i][j] * cw[j];
                end
                r = round_clamp(acc, MAT_FRAC);
                if (k == 0 || r < lo[i]) lo[i] = r;
                if (k == 0 || r > hi[i]) hi[i] = r;
            end
        end

        bx[BOX_MIN_X] = lo[0];
        bx[BOX_MIN_Y] = lo[1];
        bx[BOX_MIN_Z] = lo[2];
        bx[BOX_MAX_X] = hi[0];
        bx[BOX_MAX_Y] = hi[1];
        bx[BOX_MAX_Z] = hi[2];
        return bx;
    endfunction

    // ------------------------------------------------------------------
    // Input driver: change at the falling edge, hold until accepted
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        t_pose nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (offered_cnt == accepted_cnt) begin
            // Previous word is gone (or there was none): offer the next or idle.
            if (pose_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                nxt = pose_backlog.pop_front();
                i_pos_x    <= nxt.pos_x;
                i_pos_y    <= nxt.pos_y;
                i_pos_z    <= nxt.pos_z;
                i_rot_w    <= nxt.rot_w;
                i_rot_x    <= nxt.rot_x;
                i_rot_y    <= nxt.rot_y;
                i_rot_z    <= nxt.rot_z;
                i_scale_x  <= nxt.scale_x;
                i_scale_y  <= nxt.scale_y;
                i_scale_z  <= nxt.scale_z;
                i_in_valid <= 1'b1;
                offered_cnt++;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        // else: hold the word and valid until the block takes it
    end

    // ------------------------------------------------------------------
    // Output receiver: random stalls plus the occasional long hold-off
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (stall_req_cnt != stall_ack_cnt) begin
            stall_ack_cnt = stall_req_cnt;
            hold_left     = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= ready_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Monitor and scoreboard: sample at the rising edge
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_box  got;
        t_box  want;
        t_pose p;
        if (i_rst_n) begin
            // Check the output word against the oldest prediction.
            if (o_out_valid && i_out_ready) begin
                got[BOX_MIN_X] = o_box_min_x;
                got[BOX_MIN_Y] = o_box_min_y;
                got[BOX_MIN_Z] = o_box_min_z;
                got[BOX_MAX_X] = o_box_max_x;
                got[BOX_MAX_Y] = o_box_max_y;
                got[BOX_MAX_Z] = o_box_max_z;
                if (expected_boxes.size() == 0) begin
                    error_cnt++;
                    if (error_cnt <= REPORT_LIMIT)
                        $display("[%0t] output word with nothing pending: %h", $realtime, got);
                end else begin
                    want = expected_boxes.pop_front();
                    for (int f = 0; f < 6; f++) begin
                        if (got[f] !== want[f]) begin
                            error_cnt++;
                            if (error_cnt <= REPORT_LIMIT)
                                $display("[%0t] word %0d %s: expected %h, got %h",
                                         $realtime, checked_cnt, box_field[f],
                                         want[f], got[f]);
                        end
                    end
                    checked_cnt++;
                end
            end
            // Predict the word the block takes at this edge.
            if (i_in_valid && o_in_ready) begin
                p.pos_x   = i_pos_x;
                p.pos_y   = i_pos_y;
                p.pos_z   = i_pos_z;
                p.rot_w   = i_rot_w;
                p.rot_x   = i_rot_x;
                p.rot_y   = i_rot_y;
                p.rot_z   = i_rot_z;
                p.scale_x = i_scale_x;
                p.scale_y = i_scale_y;
                p.scale_z = i_scale_z;
                expected_boxes.push_back(world_box(p));
                accepted_cnt++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Write one register at the next falling edge; track it in the mirror.
    task automatic write_reg(input t_cfg_idx idx, input t_coord data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_EXT_MIN_X: ext_lo[0] = data;
            CFG_EXT_MIN_Y: ext_lo[1] = data;
            CFG_EXT_MIN_Z: ext_lo[2] = data;
            CFG_EXT_MAX_X: ext_hi[0] = data;
            CFG_EXT_MAX_Y: ext_hi[1] = data;
            CFG_EXT_MAX_Z: ext_hi[2] = data;
            default: ;   // no register there: drop
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic load_extents(input t_coord lx, ly, lz, hx, hy, hz);
        write_reg(CFG_EXT_MIN_X, lx);
        write_reg(CFG_EXT_MIN_Y, ly);
        write_reg(CFG_EXT_MIN_Z, lz);
        write_reg(CFG_EXT_MAX_X, hx);
        write_reg(CFG_EXT_MAX_Y, hy);
        write_reg(CFG_EXT_MAX_Z, hz);
        setting_cnt++;
    endtask

    // Block until every queued pose has been taken and every word checked.
    task automatic wait_drained();
        while (pose_backlog.size() != 0 || offered_cnt != accepted_cnt ||
               expected_boxes.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic queue_pose(input t_coord px, py, pz, input t_quat qw, qx, qy, qz,
                              input t_coord sx, sy, sz);
        t_pose p;
        p = '{px, py, pz, qw, qx, qy, qz, sx, sy, sz};
        pose_backlog.push_back(p);
    endtask

    // Signed value of random magnitude: full width, a rail, or shifted down.
    function automatic t_coord rand_coord(input int min_shift, input int max_shift);
        t_coord v;
        v = $urandom;
        case ($urandom_range(0, 7))
            0:       return v;
            1:       return $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
            default: return v >>> $urandom_range(min_shift, max_shift);
        endcase
    endfunction

    // Mostly realistic poses (unit quaternions, moderate scale), some noise.
    task automatic queue_random(input int n);
        t_pose p;
        t_quat qv [4];
        real   a [4];
        real   norm;
        int    sel;
        int    ax;
        for (int it = 0; it < n; it++) begin
            sel = $urandom_range(0, 9);
            if (sel <= 5) begin
                // random unit quaternion
                norm = 0.0;
                for (int j = 0; j < 4; j++) begin
                    a[j] = real'(int'($urandom_range(0, 2000)) - 1000);
                    norm = norm + a[j] * a[j];
                end
                norm = $sqrt(norm);
                for (int j = 0; j < 4; j++) begin
                    qv[j] = (norm < 1.0) ? ((j == 0) ? Q_ONE : t_quat'(0))
                                         : t_quat'($rtoi(a[j] / norm * 16384.0));
                end
            end else if (sel <= 7) begin
                // raw bits: non-unit and sheared boxes
                for (int j = 0; j < 4; j++) qv[j] = t_quat'($urandom);
            end else if (sel == 8) begin
                // quarter and half turns about one axis
                ax = $urandom_range(1, 3);
                for (int j = 0; j < 4; j++) qv[j] = '0;
                if ($urandom_range(0, 1)) begin
                    qv[0]  = $urandom_range(0, 1) ? Q_RT_HALF : -Q_RT_HALF;
                    qv[ax] = $urandom_range(0, 1) ? Q_RT_HALF : -Q_RT_HALF;
                end else begin
                    qv[ax] = $urandom_range(0, 1) ? Q_ONE : -Q_ONE;
                end
            end else begin
                for (int j = 0; j < 4; j++) begin
                    case ($urandom_range(0, 2))
                        0:       qv[j] = Q_POS_MAX;
                        1:       qv[j] = Q_NEG_MAX;
                        default: qv[j] = '0;
                    endcase
                end
            end
            p.rot_w   = qv[0];
            p.rot_x   = qv[1];
            p.rot_y   = qv[2];
            p.rot_z   = qv[3];
            p.pos_x   = rand_coord(4, 28);
            p.pos_y   = rand_coord(4, 28);
            p.pos_z   = rand_coord(4, 28);
            p.scale_x = rand_coord(10, 20);
            p.scale_y = rand_coord(10, 20);
            p.scale_z = rand_coord(10, 20);
            pose_backlog.push_back(p);
        end
    endtask

    // ------------------------------------------------------------------
    // Run time limit
    // ------------------------------------------------------------------
    initial begin
        #(TIMEOUT_CYCLES * 2 * CLK_HALF);
        $display("timeout after %0d cycles, %0d words still pending",
                 TIMEOUT_CYCLES, expected_boxes.size());
        $display("obb_world_bounding_box test failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        t_coord mx;
        t_coord my;
        t_coord mz;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Extents at reset are zero: the box collapses onto the position.
        queue_pose(COORD_MAX, COORD_MIN, '0, Q_ONE, '0, '0, '0, FIX_ONE, FIX_ONE, FIX_ONE);
        queue_pose(32'sh1234_5678, -32'sh0000_0001, 32'sh0000_8000,
                   Q_RT_HALF, '0, Q_RT_HALF, '0, COORD_MIN, COORD_MAX, FIX_HALF);
        wait_drained();

        // Unit box; stray writes to unmapped indexes must leave it alone.
        load_extents(-FIX_ONE, -FIX_ONE, -FIX_ONE, FIX_ONE, FIX_ONE, FIX_ONE);
        write_reg(CFG_IDX_UNMAPPED_6, 32'h5a5a_a5a5);
        write_reg(CFG_IDX_UNMAPPED_7, 32'hffff_ffff);
        queue_pose('0, '0, '0, Q_ONE, '0, '0, '0, FIX_ONE, FIX_ONE, FIX_ONE);
        queue_pose(32'sh0003_0000, '0, -32'sh0002_0000, Q_RT_HALF, '0, '0, Q_RT_HALF,
                   32'sh0002_0000, FIX_ONE, FIX_HALF);
        queue_pose('0, 32'sh0000_4000, '0, '0, Q_ONE, '0, '0,
                   FIX_ONE, 32'sh0003_0000, FIX_ONE);
        // non-unit quaternions at both rails and all zero
        queue_pose('0, '0, '0, Q_POS_MAX, Q_POS_MAX, Q_POS_MAX, Q_POS_MAX,
                   FIX_ONE, FIX_ONE, FIX_ONE);
        queue_pose('0, '0, '0, Q_NEG_MAX, Q_NEG_MAX, Q_NEG_MAX, Q_NEG_MAX,
                   FIX_ONE, FIX_ONE, FIX_ONE);
        queue_pose(32'sh0000_0001, '0, '0, '0, '0, '0, '0, FIX_ONE, FIX_ONE, FIX_ONE);
        // negative scale flips the corners
        queue_pose('0, '0, '0, Q_ONE, '0, '0, '0, -32'sh0003_0000, -FIX_HALF, -FIX_ONE);
        // scale rails: scaled extents clamp
        queue_pose('0, '0, '0, Q_ONE, '0, '0, '0, COORD_MAX, COORD_MAX, COORD_MAX);
        queue_pose('0, '0, '0, Q_ONE, '0, '0, '0, COORD_MIN, COORD_MIN, COORD_MIN);
        // position rails: world corners clamp
        queue_pose(COORD_MAX, COORD_MAX, COORD_MAX, Q_ONE, '0, '0, '0,
                   FIX_ONE, FIX_ONE, FIX_ONE);
        queue_pose(COORD_MIN, COORD_MIN, COORD_MIN, Q_RT_HALF, Q_RT_HALF, '0, '0,
                   32'sh0010_0000, 32'sh0010_0000, 32'sh0010_0000);
        queue_pose(32'sh1234_5678, 32'shfedc_ba98, 32'sh0000_0001, -Q_ONE, '0, '0, '0,
                   32'sh0000_0001, 32'sh7fff_0000, 32'sh8000_ffff);
        queue_pose(32'sh0000_7fff, -32'sh0000_8000, '0, 16'sd8192, 16'sd8192,
                   16'sd8192, 16'sd8192, 32'sh0001_8000, 32'sh0000_0003, -32'sh0000_0003);
        wait_drained();

        // Minimum above maximum on every axis.
        load_extents(32'sh0002_8000, 32'sh0003_0000, 32'sh0000_4000,
                     -FIX_ONE, -32'sh0007_c000, '0);
        queue_pose('0, '0, '0, Q_ONE, '0, '0, '0, FIX_ONE, FIX_ONE, FIX_ONE);
        queue_pose(32'sh0100_0000, '0, '0, Q_RT_HALF, '0, Q_RT_HALF, '0,
                   -FIX_ONE, 32'sh0002_0000, FIX_ONE);
        queue_pose('0, '0, '0, '0, '0, '0, Q_ONE, FIX_HALF, FIX_HALF, FIX_HALF);
        wait_drained();

        // Widest possible box.
        load_extents(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX);
        queue_pose('0, '0, '0, Q_ONE, '0, '0, '0, FIX_ONE, FIX_ONE, FIX_ONE);
        queue_pose('0, '0, '0, Q_ONE, '0, '0, '0, 32'sh0000_0001, 32'sh0000_0001, '0);
        queue_pose(COORD_MIN, '0, COORD_MAX, Q_RT_HALF, '0, '0, -Q_RT_HALF,
                   FIX_HALF, -FIX_HALF, 32'sh0000_0002);
        wait_drained();

        // Phase 0: no idling; random extents; force a long output hold-off
        // so the pipeline fills and backs up into the input.
        send_idle_pct   = 0;
        ready_stall_pct = 0;
        load_extents(rand_coord(4, 24), rand_coord(4, 24), rand_coord(4, 24),
                     rand_coord(4, 24), rand_coord(4, 24), rand_coord(4, 24));
        queue_random(ITEMS_PER_PASS);
        stall_req_cnt++;
        wait_drained();

        // Phase 1: sender idles often; swapped extreme extents.
        send_idle_pct   = 57;
        ready_stall_pct = 0;
        load_extents(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN);
        queue_random(ITEMS_PER_PASS);
        wait_drained();

        // Phase 2: receiver stalls often; raw full-width extents.
        send_idle_pct   = 0;
        ready_stall_pct = 57;
        load_extents($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        queue_random(ITEMS_PER_PASS);
        wait_drained();

        // Phase 3: both sides gap; symmetric box about the origin.
        send_idle_pct   = 35;
        ready_stall_pct = 35;
        mx = rand_coord(8, 20);
        my = rand_coord(8, 20);
        mz = rand_coord(8, 20);
        load_extents(-mx, -my, -mz, mx, my, mz);
        queue_random(ITEMS_PER_PASS);
        wait_drained();

        // Let any stray word show up before closing out.
        ready_stall_pct = 0;
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (expected_boxes.size() != 0) begin
            $display("%0d predicted words never arrived", expected_boxes.size());
            error_cnt += expected_boxes.size();
        end

        $display("covered %0d poses over %0d extent settings and four handshake mixes",
                 accepted_cnt, setting_cnt);
        $display("compared %0d output words, %0d errors", checked_cnt, error_cnt);
        if (error_cnt == 0) begin
            $display("obb_world_bounding_box test passed");
        end else begin
            $display("obb_world_bounding_box test failed");
        end
        $finish;
    end

endmodule

FILE: obb_world_bounding_box.f
design/obbwb_pkg.sv
design/obbwb_quat_mat.sv
design/obbwb_ext_scale.sv
design/obbwb_corner_axis.sv
design/obb_world_bounding_box.sv
test/obb_world_bounding_box_test.sv
